/* rtl/core/bzc_pkg.sv */
// Package for the sensorless BLDC zero-cross commutation timing block: codes and constants.
package bzc_pkg;

    // Default parameter values
    localparam int TIMER_BITS_DEF = 16;
    localparam int NUM_STEPS_DEF  = 6;

    // Field and register widths
    localparam int MODE_W   = 2;
    localparam int PHASE_W  = 3;
    localparam int PERIOD_W = 16;
    localparam int CONF_W   = 5;
    localparam int LIMIT_W  = 16;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REGIDX_W = 3;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

    // Register indexes
    localparam logic [REGIDX_W-1:0] REG_STARTUP_PERIOD  = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_STARTUP_CONFIRM = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_SLOW_CONFIRM    = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_FAST_LIMIT      = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_MID_LIMIT       = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_SLOW_LIMIT      = 3'd5;

    // Register reset values
    localparam logic [PERIOD_W-1:0] STARTUP_PERIOD_RST  = 16'd5000;
    localparam logic [CONF_W-1:0]   STARTUP_CONFIRM_RST = 5'd15;
    localparam logic [CONF_W-1:0]   SLOW_CONFIRM_RST    = 5'd10;
    localparam logic [LIMIT_W-1:0]  FAST_LIMIT_RST      = 16'd300;
    localparam logic [LIMIT_W-1:0]  MID_LIMIT_RST       = 16'd800;
    localparam logic [LIMIT_W-1:0]  SLOW_LIMIT_RST      = 16'd1500;

    // Period after reset, before any start
    localparam logic [31:0] PERIOD_RST = 32'h0000_ffff;

    // Confirmation floors per speed band
    localparam logic [CONF_W-1:0] CONFIRM_FAST = 5'd2;
    localparam logic [CONF_W-1:0] CONFIRM_MID  = 5'd3;
    localparam logic [CONF_W-1:0] CONFIRM_SLOW = 5'd5;

endpackage

/* rtl/core/bldc_zero_cross_commutation_timing_top.sv */
// Sensorless BLDC commutation timing: back-EMF zero-cross confirm, period average, step sequencing.
//
//  channel | signals                                         | direction | payload
//  --------+-------------------------------------------------+-----------+------------------------
//  in      | i_in_valid / o_in_ready                         | to block  | i_mode, i_comp_out
//  out     | o_out_valid / i_out_ready                       | from block| commutate, step, period..
//  cfg     | psel penable pwrite paddr pwdata prdata pready  | both      | six timing registers
//
// One request per clock while the output register can take it; its result is registered there on acceptance.
// All timing state updates in a single pass of compares, shifts and one add chain per tick.
// A new request is taken whenever the output register is empty or is drained in that cycle.
// i_rst_n is synchronous, active low; timing state, config registers and out-valid return to defaults at once.
module bldc_zero_cross_commutation_timing_top
    import bzc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int NUM_STEPS  = NUM_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic                i_comp_out,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_commutate,
    output logic [PHASE_W-1:0]  o_phase_step,
    output logic [PHASE_W-1:0]  o_comparator_select,
    output logic                o_zero_cross,
    output logic                o_open_loop,
    output logic [PERIOD_W-1:0] o_period,
    output logic                o_running,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int TW  = TIMER_BITS;
    localparam int SW  = (NUM_STEPS > 2) ? $clog2(NUM_STEPS) : 1;
    localparam int SXW = (SW > PHASE_W) ? SW : PHASE_W;
    localparam int CW  = (TW > LIMIT_W) ? TW : LIMIT_W;

    // configuration registers
    logic [PERIOD_W-1:0] r_startup_period;
    logic [CONF_W-1:0]   r_startup_confirm;
    logic [CONF_W-1:0]   r_slow_confirm;
    logic [LIMIT_W-1:0]  r_fast_limit;
    logic [LIMIT_W-1:0]  r_mid_limit;
    logic [LIMIT_W-1:0]  r_slow_limit;

    // timing state
    logic              r_running,   n_running;
    logic              r_open_loop, n_open_loop;
    logic              r_detect,    n_detect;
    logic [TW-1:0]     r_cc,        n_cc;
    logic [TW-1:0]     r_pr,        n_pr;
    logic [TW-1:0]     r_bc,        n_bc;
    logic [TW-1:0]     r_ci,        n_ci;
    logic [CONF_W-1:0] r_cl,        n_cl;
    logic [CONF_W-1:0] r_cn,        n_cn;
    logic [CONF_W-1:0] r_rcn,       n_rcn;
    logic [SW-1:0]     r_step,      n_step;

    // result register
    logic                r_out_valid;
    logic                r_out_commutate;
    logic [PHASE_W-1:0]  r_out_phase;
    logic [PHASE_W-1:0]  r_out_csel;
    logic                r_out_cross;
    logic                r_out_open_loop;
    logic [PERIOD_W-1:0] r_out_period;
    logic                r_out_running;

    logic                in_accept;
    logic                cfg_write;
    logic [REGIDX_W-1:0] reg_idx;
    logic                n_commutate;
    logic                n_crossed;
    logic [SXW-1:0]      csel_sum;

    // zero-cross evaluation, all on start-of-tick state
    logic [CONF_W-1:0] cl_dec;
    logic [TW-1:0]     half_p;
    logic [TW:0]       late_lim;
    logic              cross_early;
    logic              cross_late;
    logic [CW-1:0]     ci_ext;
    logic [TW-1:0]     avg_p;
    logic [TW-1:0]     avg_cc;
    logic [CONF_W-1:0] rcn_adapt;
    logic [TW-1:0]     start_p;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign reg_idx    = paddr[ADDR_W-1:2];

    assign start_p  = TW'(r_startup_period);
    assign cl_dec   = (r_cl != '0) ? r_cl - 1'b1 : '0;
    assign half_p   = r_pr >> 1;
    assign late_lim = {r_pr, 1'b0} - (TW+1)'(r_pr >> 3);
    assign cross_early = r_ci < half_p;
    assign cross_late  = {1'b0, r_ci} > late_lim;
    assign ci_ext   = CW'(r_ci);
    assign avg_p    = half_p + (r_ci >> 1);
    assign avg_cc   = (avg_p >> 1) + (avg_p >> 2);

    // confirmation count follows the interval band
    always_comb begin
        rcn_adapt = r_rcn;
        priority if (ci_ext < CW'(r_fast_limit)) begin
            if (r_rcn > CONFIRM_FAST) rcn_adapt = r_rcn - 1'b1;
        end else if (ci_ext < CW'(r_mid_limit)) begin
            if (r_rcn > CONFIRM_MID) rcn_adapt = r_rcn - 1'b1;
        end else if (ci_ext < CW'(r_slow_limit)) begin
            if (r_rcn > CONFIRM_SLOW) rcn_adapt = r_rcn - 1'b1;
        end else begin
            if (r_rcn < r_slow_confirm) rcn_adapt = r_rcn + 1'b1;
        end
    end

    always_comb begin
        n_running   = r_running;
        n_open_loop = r_open_loop;
        n_detect    = r_detect;
        n_cc        = r_cc;
        n_pr        = r_pr;
        n_bc        = r_bc;
        n_ci        = r_ci;
        n_cl        = r_cl;
        n_cn        = r_cn;
        n_rcn       = r_rcn;
        n_step      = r_step;
        n_commutate = 1'b0;
        n_crossed   = 1'b0;
        if (in_accept) begin
            unique case (i_mode)
                MODE_START: begin
                    n_open_loop = 1'b1;
                    n_running   = 1'b1;
                    n_detect    = 1'b0;
                    n_cc        = TW'(1);
                    n_pr        = start_p;
                    n_bc        = start_p >> 4;
                    n_cl        = r_cn;
                    n_step      = '0;
                    n_ci        = start_p >> 1;
                end
                MODE_STOP: begin
                    n_running = 1'b0;
                    n_detect  = 1'b0;
                end
                MODE_TICK: begin
                    if (r_running) begin
                        // zero-cross confirmation
                        if (r_detect) begin
                            if (!i_comp_out) begin
                                n_cl = r_cn;
                            end else begin
                                n_cl = cl_dec;
                                if (cl_dec == '0) begin
                                    n_crossed = 1'b1;
                                    n_ci      = '0;
                                    n_detect  = 1'b0;
                                    if (r_open_loop) begin
                                        n_open_loop = 1'b0;
                                    end else if (cross_early) begin
                                        // too early: back to startup timing
                                        n_open_loop = 1'b1;
                                        n_cn        = r_startup_confirm;
                                        n_cl        = r_startup_confirm;
                                        n_pr        = start_p;
                                    end else if (!cross_late) begin
                                        n_rcn = rcn_adapt;
                                        n_cn  = rcn_adapt;
                                        n_pr  = avg_p;
                                        n_cc  = avg_cc;
                                    end
                                    n_bc = n_pr >> 3;
                                end
                            end
                        end
                        // commutation counter
                        if (n_cc >= n_pr) begin
                            n_cc        = '0;
                            n_step      = (r_step == SW'(NUM_STEPS - 1)) ? '0 : r_step + 1'b1;
                            n_detect    = 1'b0;
                            n_cl        = n_cn;
                            n_commutate = 1'b1;
                        end else begin
                            n_cc = n_cc + 1'b1;
                        end
                        // end of blanking
                        if (n_cc == n_bc) begin
                            n_cl     = n_cn;
                            n_detect = 1'b1;
                        end
                        // interval timer, overflow forces open loop
                        if (!n_crossed) begin
                            if (r_ci == '1) begin
                                n_ci        = '0;
                                n_open_loop = 1'b1;
                                n_cl        = n_cn;
                            end else begin
                                n_ci = r_ci + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign csel_sum = SXW'(n_step) + SXW'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_open_loop <= 1'b1;
            r_detect    <= 1'b0;
            r_cc        <= '0;
            r_pr        <= TW'(PERIOD_RST);
            r_bc        <= '0;
            r_ci        <= '0;
            r_cl        <= STARTUP_CONFIRM_RST;
            r_cn        <= STARTUP_CONFIRM_RST;
            r_rcn       <= SLOW_CONFIRM_RST;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_running   <= n_running;
            r_open_loop <= n_open_loop;
            r_detect    <= n_detect;
            r_cc        <= n_cc;
            r_pr        <= n_pr;
            r_bc        <= n_bc;
            r_ci        <= n_ci;
            r_cl        <= n_cl;
            r_cn        <= n_cn;
            r_rcn       <= n_rcn;
            r_step      <= n_step;
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_commutate <= n_commutate;
            r_out_phase     <= PHASE_W'(n_step);
            r_out_csel      <= csel_sum[PHASE_W-1:0];
            r_out_cross     <= n_crossed;
            r_out_open_loop <= n_open_loop;
            r_out_period    <= PERIOD_W'(n_pr);
            r_out_running   <= n_running;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_startup_period  <= STARTUP_PERIOD_RST;
            r_startup_confirm <= STARTUP_CONFIRM_RST;
            r_slow_confirm    <= SLOW_CONFIRM_RST;
            r_fast_limit      <= FAST_LIMIT_RST;
            r_mid_limit       <= MID_LIMIT_RST;
            r_slow_limit      <= SLOW_LIMIT_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_STARTUP_PERIOD:  r_startup_period  <= pwdata[PERIOD_W-1:0];
                REG_STARTUP_CONFIRM: r_startup_confirm <= pwdata[CONF_W-1:0];
                REG_SLOW_CONFIRM:    r_slow_confirm    <= pwdata[CONF_W-1:0];
                REG_FAST_LIMIT:      r_fast_limit      <= pwdata[LIMIT_W-1:0];
                REG_MID_LIMIT:       r_mid_limit       <= pwdata[LIMIT_W-1:0];
                REG_SLOW_LIMIT:      r_slow_limit      <= pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STARTUP_PERIOD:  prdata = DATA_W'(r_startup_period);
            REG_STARTUP_CONFIRM: prdata = DATA_W'(r_startup_confirm);
            REG_SLOW_CONFIRM:    prdata = DATA_W'(r_slow_confirm);
            REG_FAST_LIMIT:      prdata = DATA_W'(r_fast_limit);
            REG_MID_LIMIT:       prdata = DATA_W'(r_mid_limit);
            REG_SLOW_LIMIT:      prdata = DATA_W'(r_slow_limit);
            default:             prdata = '0;
        endcase
    end

    assign o_out_valid         = r_out_valid;
    assign o_commutate         = r_out_commutate;
    assign o_phase_step        = r_out_phase;
    assign o_comparator_select = r_out_csel;
    assign o_zero_cross        = r_out_cross;
    assign o_open_loop         = r_out_open_loop;
    assign o_period            = r_out_period;
    assign o_running           = r_out_running;

    // step stays inside the commutation sequence
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_step) < NUM_STEPS)
        else $error("commutation step out of range");

    // detection is only ever armed while the motor runs
    a_detect_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> !r_detect)
        else $error("detection armed while stopped");

    // a start request puts the timers into their open-loop startup state
    a_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_mode == MODE_START) |=>
            (r_open_loop && r_running && !r_detect && r_cc == TW'(1)
             && r_ci == (r_pr >> 1) && r_step == '0))
        else $error("start did not load startup timing");

    // commutation and zero cross are reported only while running
    a_events_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_commutate || r_out_cross)) |-> r_out_running)
        else $error("timing event reported while stopped");

endmodule

/* tb/sv/tb.sv */
// Testbench for the BLDC zero-cross commutation timing block: directed and random requests.
module tb
    import bzc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTEPS      = NUM_STEPS_DEF;
    localparam int NUM_REGS    = 6;
    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 170;
    localparam logic [MODE_W-1:0]   MODE_SPARE = 2'd3;
    localparam logic [PERIOD_W-1:0] TIMER_MAX  = 16'hffff;

    typedef struct packed {
        logic                commutate;
        logic [PHASE_W-1:0]  step;
        logic [PHASE_W-1:0]  comp_sel;
        logic                zero_cross;
        logic                open_loop;
        logic [PERIOD_W-1:0] period;
        logic                running;
    } t_timing_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [MODE_W-1:0]   i_mode = MODE_TICK;
    logic                i_comp_out = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_commutate;
    logic [PHASE_W-1:0]  o_phase_step;
    logic [PHASE_W-1:0]  o_comparator_select;
    logic                o_zero_cross;
    logic                o_open_loop;
    logic [PERIOD_W-1:0] o_period;
    logic                o_running;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    bldc_zero_cross_commutation_timing_top uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // expected timing results, oldest first
    t_timing_result expected_timing_q[$];
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          gap_max = 15;
    int          stall_max = 15;
    int          hold_cycles = 0;
    bit          offering = 1'b0;

    // shadow of the block's timing state and registers
    logic                run_on, ol_on, detect_on;
    logic [PERIOD_W-1:0] comm_cnt, period_r, blank_cmp, xint_cnt;
    logic [CONF_W-1:0]   conf_left, conf_need, run_conf;
    logic [PHASE_W-1:0]  step_r;
    logic [15:0]         cfg_val [NUM_REGS];

    task automatic note_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        mismatch_count++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
    endtask

    function automatic logic [31:0] reg_mask(input logic [REGIDX_W-1:0] idx);
        if (idx == REG_STARTUP_CONFIRM || idx == REG_SLOW_CONFIRM)
            return 32'h1f;
        return 32'hffff;
    endfunction

    task automatic reset_predictor();
        cfg_val[REG_STARTUP_PERIOD]  = STARTUP_PERIOD_RST;
        cfg_val[REG_STARTUP_CONFIRM] = 16'(STARTUP_CONFIRM_RST);
        cfg_val[REG_SLOW_CONFIRM]    = 16'(SLOW_CONFIRM_RST);
        cfg_val[REG_FAST_LIMIT]      = FAST_LIMIT_RST;
        cfg_val[REG_MID_LIMIT]       = MID_LIMIT_RST;
        cfg_val[REG_SLOW_LIMIT]      = SLOW_LIMIT_RST;
        run_on    = 1'b0;
        ol_on     = 1'b1;
        detect_on = 1'b0;
        comm_cnt  = '0;
        period_r  = PERIOD_RST[PERIOD_W-1:0];
        blank_cmp = '0;
        xint_cnt  = '0;
        conf_left = STARTUP_CONFIRM_RST;
        conf_need = STARTUP_CONFIRM_RST;
        run_conf  = SLOW_CONFIRM_RST;
        step_r    = '0;
    endtask

    // confirmed zero cross: leave open loop, fall back, ignore, or average the period
    function automatic void zero_cross_update(input logic [PERIOD_W-1:0] cnt);
        int unsigned p, c, np;
        p = period_r;
        c = cnt;
        xint_cnt = '0;
        if (ol_on) begin
            ol_on = 1'b0;
        end else if (c < p / 2) begin
            ol_on     = 1'b1;
            conf_need = cfg_val[REG_STARTUP_CONFIRM][CONF_W-1:0];
            conf_left = conf_need;
            period_r  = cfg_val[REG_STARTUP_PERIOD];
        end else if (c <= 2 * p - p / 8) begin
            if (c < cfg_val[REG_FAST_LIMIT]) begin
                if (run_conf > CONFIRM_FAST) run_conf--;
            end else if (c < cfg_val[REG_MID_LIMIT]) begin
                if (run_conf > CONFIRM_MID) run_conf--;
            end else if (c < cfg_val[REG_SLOW_LIMIT]) begin
                if (run_conf > CONFIRM_SLOW) run_conf--;
            end else begin
                if (run_conf < cfg_val[REG_SLOW_CONFIRM][CONF_W-1:0]) run_conf++;
            end
            conf_need = run_conf;
            np        = p / 2 + c / 2;
            period_r  = np[PERIOD_W-1:0];
            comm_cnt  = period_r / 2 + period_r / 4;
        end
        blank_cmp = period_r / 8;
        detect_on = 1'b0;
    endfunction

    function automatic t_timing_result predict_commutation(input logic [MODE_W-1:0] mode,
                                                           input logic comp);
        t_timing_result r;
        logic crossed, commutated;
        crossed    = 1'b0;
        commutated = 1'b0;
        case (mode)
            MODE_START: begin
                ol_on     = 1'b1;
                run_on    = 1'b1;
                detect_on = 1'b0;
                comm_cnt  = 16'd1;
                period_r  = cfg_val[REG_STARTUP_PERIOD];
                blank_cmp = period_r / 16;
                conf_left = conf_need;
                step_r    = '0;
                xint_cnt  = period_r / 2;
            end
            MODE_STOP: begin
                run_on    = 1'b0;
                detect_on = 1'b0;
            end
            MODE_TICK: begin
                if (run_on) begin
                    if (detect_on) begin
                        if (!comp) begin
                            conf_left = conf_need;
                        end else begin
                            if (conf_left > 0) conf_left--;
                            if (conf_left == 0) begin
                                zero_cross_update(xint_cnt);
                                crossed = 1'b1;
                            end
                        end
                    end
                    if (comm_cnt >= period_r) begin
                        comm_cnt   = '0;
                        step_r     = (step_r == PHASE_W'(NSTEPS - 1)) ? '0 : step_r + 1'b1;
                        detect_on  = 1'b0;
                        conf_left  = conf_need;
                        commutated = 1'b1;
                    end else begin
                        comm_cnt = comm_cnt + 1'b1;
                    end
                    if (comm_cnt == blank_cmp) begin
                        conf_left = conf_need;
                        detect_on = 1'b1;
                    end
                    // interval timer overflow drops back to open loop
                    if (!crossed) begin
                        if (xint_cnt >= TIMER_MAX) begin
                            xint_cnt  = '0;
                            ol_on     = 1'b1;
                            conf_left = conf_need;
                        end else begin
                            xint_cnt = xint_cnt + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.commutate  = commutated;
        r.step       = step_r;
        r.comp_sel   = step_r + 3'd2;
        r.zero_cross = crossed;
        r.open_loop  = ol_on;
        r.period     = period_r;
        r.running    = run_on;
        return r;
    endfunction

    task automatic apb_access(input logic wr, input logic [REGIDX_W-1:0] idx,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write with junk above the field, then read back
    task automatic program_reg(input logic [REGIDX_W-1:0] idx, input logic [15:0] value);
        logic [DATA_W-1:0] rd, mask;
        mask = reg_mask(idx);
        apb_access(1'b1, idx, ($urandom & ~mask) | (32'(value) & mask), rd);
        cfg_val[idx] = value & mask[15:0];
        apb_access(1'b0, idx, $urandom, rd);
        if (rd !== 32'(cfg_val[idx]))
            note_mismatch($sformatf("reg %0d readback", idx), rd, cfg_val[idx]);
    endtask

    task automatic drop_offer();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic issue_request(input logic [MODE_W-1:0] mode, input logic comp);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            drop_offer();
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_comp_out <= comp;
        offering = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        expected_timing_q.push_back(predict_commutation(mode, comp));
    endtask

    task automatic wait_for_drain();
        drop_offer();
        do @(posedge i_clk); while (expected_timing_q.size() != 0);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // result receiver: random stalls, plus one long hold-off on demand
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            stall = $urandom_range(0, stall_max);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_timing_result got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_commutate, o_phase_step, o_comparator_select, o_zero_cross,
                    o_open_loop, o_period, o_running};
            if (expected_timing_q.size() == 0) begin
                note_mismatch("result with no request pending", 1, 0);
            end else begin
                want = expected_timing_q.pop_front();
                if (got.commutate !== want.commutate)
                    note_mismatch("commutate", got.commutate, want.commutate);
                if (got.step !== want.step)
                    note_mismatch("phase_step", got.step, want.step);
                if (got.comp_sel !== want.comp_sel)
                    note_mismatch("comparator_select", got.comp_sel, want.comp_sel);
                if (got.zero_cross !== want.zero_cross)
                    note_mismatch("zero_cross", got.zero_cross, want.zero_cross);
                if (got.open_loop !== want.open_loop)
                    note_mismatch("open_loop", got.open_loop, want.open_loop);
                if (got.period !== want.period)
                    note_mismatch("period", got.period, want.period);
                if (got.running !== want.running)
                    note_mismatch("running", got.running, want.running);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_register_reset();
        logic [DATA_W-1:0] rd;
        logic [15:0]       dflt;
        for (int i = 0; i < NUM_REGS; i++) begin
            apb_access(1'b0, REGIDX_W'(i), $urandom, rd);
            if (rd !== 32'(cfg_val[i]))
                note_mismatch($sformatf("reg %0d after reset", i), rd, cfg_val[i]);
        end
        for (int i = 0; i < NUM_REGS; i++) begin
            dflt = cfg_val[i];
            program_reg(REGIDX_W'(i), 16'hffff);
            program_reg(REGIDX_W'(i), 16'h0000);
            program_reg(REGIDX_W'(i), dflt);
        end
    endtask

    // nothing moves while stopped, including the unused mode code
    task automatic test_stopped_requests();
        issue_request(MODE_TICK, 1'b0);
        issue_request(MODE_TICK, 1'b1);
        issue_request(MODE_SPARE, 1'b1);
        issue_request(MODE_STOP, 1'b0);
        issue_request(MODE_SPARE, 1'b0);
    endtask

    task automatic test_open_loop_start();
        wait_for_drain();
        // zero period: commutates on every tick
        program_reg(REG_STARTUP_PERIOD, 16'd0);
        issue_request(MODE_START, 1'b1);
        repeat (2) issue_request(MODE_TICK, 1'b1);
        wait_for_drain();
        program_reg(REG_STARTUP_PERIOD, 16'd16);
        issue_request(MODE_START, 1'b0);
        repeat (18) issue_request(MODE_TICK, 1'b1);
        // restart while running, then stop
        issue_request(MODE_START, 1'b1);
        issue_request(MODE_TICK, 1'b0);
        issue_request(MODE_STOP, 1'b1);
        issue_request(MODE_TICK, 1'b1);
    endtask

    task automatic test_output_backpressure();
        wait_for_drain();
        issue_request(MODE_START, 1'b0);
        hold_cycles = 200;
        gap_max = 0;
        repeat (40) issue_request(MODE_TICK, 1'($urandom));
        gap_max = 15;
        wait_for_drain();
    endtask

    // motor-like comparator: high over the back half of each electrical cycle
    task automatic test_random_phases();
        int          vp, pos, done, roll;
        logic [MODE_W-1:0] mode;
        logic        comp;
        for (int ph = 0; ph < 6; ph++) begin
            wait_for_drain();
            case (ph)
                1: begin
                    program_reg(REG_STARTUP_PERIOD, 16'd1);
                    program_reg(REG_STARTUP_CONFIRM, 16'd31);
                    program_reg(REG_SLOW_CONFIRM, 16'd0);
                    program_reg(REG_FAST_LIMIT, 16'hffff);
                    program_reg(REG_MID_LIMIT, 16'hffff);
                    program_reg(REG_SLOW_LIMIT, 16'hffff);
                end
                2: begin
                    program_reg(REG_STARTUP_PERIOD, 16'hffff);
                    program_reg(REG_STARTUP_CONFIRM, 16'd1);
                    program_reg(REG_SLOW_CONFIRM, 16'd31);
                    program_reg(REG_FAST_LIMIT, 16'd0);
                    program_reg(REG_MID_LIMIT, 16'd0);
                    program_reg(REG_SLOW_LIMIT, 16'd0);
                end
                default: begin
                    program_reg(REG_STARTUP_PERIOD, 16'($urandom_range(8, 300)));
                    program_reg(REG_STARTUP_CONFIRM,
                                (ph == 3) ? 16'd0 : 16'($urandom_range(1, 6)));
                    program_reg(REG_SLOW_CONFIRM, 16'($urandom_range(1, 31)));
                    program_reg(REG_FAST_LIMIT, 16'($urandom_range(0, 150)));
                    program_reg(REG_MID_LIMIT, 16'($urandom_range(0, 300)));
                    program_reg(REG_SLOW_LIMIT, 16'($urandom_range(0, 500)));
                end
            endcase
            issue_request(MODE_START, 1'($urandom));
            vp   = $urandom_range(8, 150);
            pos  = 0;
            done = 0;
            while (done < PHASE_ITEMS) begin
                if (done % 50 == 0) begin
                    gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 15;
                    stall_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
                end
                roll = $urandom_range(0, 199);
                if (roll < 2)      mode = MODE_START;
                else if (roll < 4) mode = MODE_STOP;
                else if (roll < 6) mode = MODE_SPARE;
                else               mode = MODE_TICK;
                if (!run_on && mode == MODE_TICK && $urandom_range(0, 7) == 0)
                    mode = MODE_START;
                // occasional speed change forces early and missed crosses
                if ($urandom_range(0, 63) == 0) vp = $urandom_range(8, 150);
                pos  = (pos + 1) % vp;
                comp = (pos >= vp / 2);
                if ($urandom_range(0, 15) == 0) comp = !comp;
                if (run_on || mode == MODE_START || mode == MODE_STOP) done++;
                issue_request(mode, comp);
            end
        end
        gap_max   = 15;
        stall_max = 15;
    endtask

    initial begin
        reset_predictor();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_stopped_requests();
        test_open_loop_start();
        test_output_backpressure();
        test_random_phases();
        wait_for_drain();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
